// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker files
// clocked on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold in the cycle that follows ante
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/apfr_pkg.sv =====
// shared constants, types and helpers for the pcm ring fifo frame reader
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package apfr_pkg;

    localparam int FRAME_SAMPLES = 48;
    localparam int RING_DEPTH    = 192;

    localparam int IDX_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FRAME_CNT_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
    localparam int ADC_W       = 12;
    localparam int PCM_W       = 16;
    localparam int PCM_SHIFT   = 4;

    localparam logic [ADC_W-1:0] ADC_OFFSET = ADC_W'(2048);

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [FRAME_CNT_W-1:0] frame_cnt_t;
    typedef logic [PCM_W-1:0]       pcm_t;

    // one step around the ring
    function automatic idx_t ring_next(input idx_t idx);
        idx_t nxt;
        if (idx == IDX_W'(RING_DEPTH - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = idx + IDX_W'(1);
        end
        return nxt;
    endfunction

    // offset binary to two's complement, scaled to full 16-bit range
    function automatic pcm_t to_pcm(input logic [ADC_W-1:0] adc);
        logic [ADC_W-1:0] centered;
        centered = adc - ADC_OFFSET;
        return {centered, {PCM_SHIFT{1'b0}}};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/apfr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module apfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/adc_pcm_ring_fifo_frame_reader_top.sv =====
// top level of the pcm ring fifo frame reader
// depends on apfr_pkg and apfr_ram
//
// usage:
//   a request is taken at a rising edge with start high and busy low.
//   opcode push converts adc_sample to pcm16 and stores it in a ring of
//   RING_DEPTH entries (RING_DEPTH-1 usable); a push into a full ring is
//   dropped. a push never raises busy, so pushes can arrive every cycle
//   while busy is low.
//   opcode frame streams FRAME_SAMPLES results, one per cycle, each shown
//   for one cycle with result_valid high. the first result appears in the
//   cycle after the request (registered ram read). once the ring runs dry the
//   remaining results carry zero with underrun set; last_in_frame marks
//   the final one.
//   busy stays high after a frame request until the frame's last read is
//   issued, so a frame holds the request port, set by the single read port
//   of the sample ram.
//   the receiver cannot stall; results must be taken when shown.
//   reset empties the ring at once (both pointers cleared); the sample ram
//   needs no clearing since only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module adc_pcm_ring_fifo_frame_reader_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      opcode,
    input  wire logic [apfr_pkg::ADC_W-1:0] adc_sample,
    output logic                           result_valid,
    output logic signed [apfr_pkg::PCM_W-1:0] pcm_sample,
    output logic                           underrun,
    output logic                           last_in_frame
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    apfr_pkg::frame_cnt_t  cnt_reg, cnt_next;
    apfr_pkg::idx_t        wr_idx_reg, wr_idx_next;
    apfr_pkg::idx_t        rd_idx_reg, rd_idx_next;
    logic                  valid_reg, under_reg, last_reg;

    logic                  push_req;
    logic                  frame_req;
    logic                  issue;
    logic                  issue_last;
    apfr_pkg::frame_cnt_t  issue_cnt;
    logic                  ring_empty;
    logic                  ring_full;
    logic                  write_en;
    logic                  read_hit;
    apfr_pkg::pcm_t        ram_rdata;

    assign busy      = (state_reg == ST_RUN);
    assign push_req  = start && !busy && (opcode == apfr_pkg::OP_PUSH);
    assign frame_req = start && !busy && (opcode == apfr_pkg::OP_FRAME);

    // the first read of a frame goes out in the request cycle itself
    assign issue      = frame_req || (state_reg == ST_RUN);
    assign issue_cnt  = frame_req ? '0 : cnt_reg;
    assign issue_last = issue
                        && (issue_cnt == apfr_pkg::FRAME_CNT_W'(apfr_pkg::FRAME_SAMPLES - 1));

    assign ring_empty = (rd_idx_reg == wr_idx_reg);
    assign ring_full  = (apfr_pkg::ring_next(wr_idx_reg) == rd_idx_reg);
    assign write_en   = push_req && !ring_full;
    assign read_hit   = issue && !ring_empty;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        wr_idx_next = write_en ? apfr_pkg::ring_next(wr_idx_reg) : wr_idx_reg;
        rd_idx_next = read_hit ? apfr_pkg::ring_next(rd_idx_reg) : rd_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_req && !issue_last)
                begin
                    state_next = ST_RUN;
                    cnt_next   = apfr_pkg::FRAME_CNT_W'(1);
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + apfr_pkg::FRAME_CNT_W'(1);
                if (issue_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            valid_reg  <= 1'b0;
            under_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            valid_reg  <= issue;
            under_reg  <= issue && ring_empty;
            last_reg   <= issue_last;
        end
    end

    apfr_ram #(
        .WIDTH (apfr_pkg::PCM_W),
        .DEPTH (apfr_pkg::RING_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (write_en),
        .waddr (wr_idx_reg),
        .wdata (apfr_pkg::to_pcm(adc_sample)),
        .re    (read_hit),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign result_valid  = valid_reg;
    assign underrun      = under_reg;
    assign last_in_frame = last_reg;
    assign pcm_sample    = under_reg ? '0 : $signed(ram_rdata);

endmodule

`default_nettype wire

// ===== rtl/apfr_checker.sv =====
// port-level checks for the pcm ring fifo frame reader, bound to the top level
// depends on apfr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module apfr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          opcode,
    input wire logic                          result_valid,
    input wire logic signed [apfr_pkg::PCM_W-1:0] pcm_sample,
    input wire logic                          underrun,
    input wire logic                          last_in_frame
);

    logic frame_taken;
    assign frame_taken = start && !busy && (opcode == apfr_pkg::OP_FRAME);

    // silence carries zero
    `ASSERT_ALWAYS(a_underrun_zero, !(result_valid && underrun) || (pcm_sample == '0),
        "underrun result with nonzero sample")
    // flags only travel with a result
    `ASSERT_ALWAYS(a_flags_with_valid, result_valid || (!underrun && !last_in_frame),
        "result flag without result_valid")
    // a frame request starts its stream in the next cycle
    `ASSERT_NEXT(a_frame_starts, frame_taken, result_valid,
        "frame request not followed by a result")
    // results keep streaming while the frame is in progress
    `ASSERT_NEXT(a_busy_streams, busy, result_valid,
        "gap in result stream during a frame")
    // once dry, the rest of the frame stays dry
    `ASSERT_NEXT(a_dry_stays_dry, result_valid && underrun && !last_in_frame,
        result_valid && underrun, "ring refilled in the middle of a frame")

endmodule

bind adc_pcm_ring_fifo_frame_reader_top apfr_checker u_apfr_checker (.*);

`default_nettype wire

// ===== tb/sv/adc_pcm_ring_fifo_frame_reader_top_tb.sv =====
// self-checking testbench for the pcm ring fifo frame reader: random push and frame requests
// are checked against a scoreboard class that predicts the ring contents and the frame results
// depends on apfr_pkg and adc_pcm_ring_fifo_frame_reader_top
`timescale 1ns / 1ps

module adc_pcm_ring_fifo_frame_reader_top_tb;

    import apfr_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int ADC_MID     = 2048;
    localparam int PCM_SCALE   = 16;
    localparam int QUIET_LIMIT = 1000;

    typedef struct {
        logic signed [PCM_W-1:0] pcm;
        logic                    under;
        logic                    last;
    } frame_word_t;

    class pcm_frame_scoreboard;
        logic signed [PCM_W-1:0] ring [RING_DEPTH];
        int unsigned wr_pos;
        int unsigned rd_pos;
        frame_word_t want_q [$];
        int errors;
        int pushes;
        int drops;
        int frames;
        int checked;
        int underruns;

        function new();
            wr_pos    = 0;
            rd_pos    = 0;
            errors    = 0;
            pushes    = 0;
            drops     = 0;
            frames    = 0;
            checked   = 0;
            underruns = 0;
        endfunction

        function int unsigned advance(int unsigned pos);
            return (pos + 1 >= RING_DEPTH) ? 0 : pos + 1;
        endfunction

        // updates the ring on a push, queues the whole frame on a frame request
        function void note_request(logic op, logic [ADC_W-1:0] adc);
            frame_word_t w;
            if (op == OP_PUSH)
            begin
                pushes++;
                if (advance(wr_pos) == rd_pos)
                begin
                    drops++;
                end
                else
                begin
                    ring[wr_pos] = PCM_W'((int'(adc) - ADC_MID) * PCM_SCALE);
                    wr_pos = advance(wr_pos);
                end
            end
            else
            begin
                frames++;
                for (int k = 0; k < FRAME_SAMPLES; k++)
                begin
                    if (rd_pos != wr_pos)
                    begin
                        w.pcm   = ring[rd_pos];
                        w.under = 1'b0;
                        rd_pos  = advance(rd_pos);
                    end
                    else
                    begin
                        w.pcm   = '0;
                        w.under = 1'b1;
                    end
                    w.last = (k == FRAME_SAMPLES - 1);
                    want_q.push_back(w);
                end
            end
        endfunction

        function void check_result(logic signed [PCM_W-1:0] pcm, logic under, logic last);
            frame_word_t w;
            checked++;
            if (want_q.size() == 0)
            begin
                errors++;
                $error("result with nothing pending: pcm_sample %0d underrun %0b", pcm, under);
                return;
            end
            w = want_q.pop_front();
            if (w.under)
                underruns++;
            if (pcm !== w.pcm)
            begin
                errors++;
                $error("pcm_sample: expected %0d, got %0d", w.pcm, pcm);
            end
            if (under !== w.under)
            begin
                errors++;
                $error("underrun: expected %0b, got %0b", w.under, under);
            end
            if (last !== w.last)
            begin
                errors++;
                $error("last_in_frame: expected %0b, got %0b", w.last, last);
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             opcode = OP_PUSH;
    logic [ADC_W-1:0] adc_sample = '0;
    logic             busy;
    logic             result_valid;
    logic signed [PCM_W-1:0] pcm_sample;
    logic             underrun;
    logic             last_in_frame;

    pcm_frame_scoreboard sb;
    int quiet_cycles = 0;
    int burst_left = 0;

    adc_pcm_ring_fifo_frame_reader_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .adc_sample    (adc_sample),
        .result_valid  (result_valid),
        .pcm_sample    (pcm_sample),
        .underrun      (underrun),
        .last_in_frame (last_in_frame)
    );

    always #HALF_PERIOD clk = ~clk;

    // monitor: results shown now belong to earlier requests, so check before noting
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_result(pcm_sample, underrun, last_in_frame);
            if (start && !busy)
                sb.note_request(opcode, adc_sample);
            if (start && !busy)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no request accepted for %0d cycles", QUIET_LIMIT);
            $display("adc_pcm_ring_fifo_frame_reader_top_tb NOT OK");
            $finish;
        end
    end

    // start low with random noise on the request fields
    task automatic idle_cycles(int n);
        for (int i = 0; i < n; i++)
        begin
            start      <= 1'b0;
            opcode     <= logic'($urandom_range(0, 1));
            adc_sample <= ADC_W'($urandom);
            @(posedge clk);
        end
    endtask

    // bursts of back-to-back requests, some preceded by a gap
    task automatic send_request(logic op, logic [ADC_W-1:0] adc);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 5));
        end
        burst_left--;
        start      <= 1'b1;
        opcode     <= op;
        adc_sample <= adc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (sb.pending() != 0)
            idle_cycles(1);
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of the converter range, then a frame that runs dry part way
        send_request(OP_PUSH, 12'd0);
        send_request(OP_PUSH, 12'd4095);
        send_request(OP_PUSH, 12'd2048);
        send_request(OP_PUSH, 12'd2047);
        send_request(OP_PUSH, 12'd1);
        send_request(OP_PUSH, 12'hAAA);
        send_request(OP_PUSH, 12'h555);
        send_request(OP_FRAME, 12'd0);
        // frame on an empty ring
        send_request(OP_FRAME, 12'hFFF);
        send_request(OP_PUSH, 12'hFFE);
        send_request(OP_FRAME, 12'h123);
        wait_drained();

        // fill past capacity so the ring wraps and late pushes are dropped
        for (int i = 0; i < RING_DEPTH + 4; i++)
            send_request(OP_PUSH, ADC_W'($urandom));
        for (int i = 0; i < 20; i++)
        begin
            if ($urandom_range(0, 99) < 70)
                send_request(OP_PUSH, ADC_W'($urandom));
            else
                send_request(OP_FRAME, ADC_W'($urandom));
        end

        wait_drained();
        idle_cycles(8);

        $display("%0d requests: %0d pushes (%0d dropped on a full ring), %0d frames",
                 sb.pushes + sb.frames, sb.pushes, sb.drops, sb.frames);
        $display("%0d results checked, %0d of them underrun silence", sb.checked, sb.underruns);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("adc_pcm_ring_fifo_frame_reader_top_tb OK");
        end
        else
        begin
            $display("adc_pcm_ring_fifo_frame_reader_top_tb NOT OK");
        end
        $finish;
    end

endmodule
